[design/mm_pkg.sv]
package mm_pkg;

  // Default sizing of the block.
  localparam int DEFAULT_MAX_DIM    = 8;
  localparam int DEFAULT_ELEM_WIDTH = 32;

  // Fixed formats of the ports and the configuration registers.
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 4;
  localparam int PADDR_W   = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // Sequencer states.
  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } mm_state_e;

  // Tag that travels with each issued pair of store reads.
  typedef struct packed {
    logic valid;
    logic last_k;
    logic last_all;
  } mm_tag_t;

endpackage

[design/matrix_multiply_top.sv]
// Fixed-point matrix multiply C = A x B. Matrix A (rows_a x inner_dim) and then
// matrix B (inner_dim x cols_b) arrive in row-major order, one element per beat,
// with s_axis_tuser selecting A (0) or B (1); each store takes one beat per cycle.
// The beat that completes B starts the product: the block then stops taking
// input until the last multiply-accumulate of C is issued, one per cycle while
// the output is not stalled, bounded by the single read port of each element
// store and the one multiplier. Each result passes the registered store reads,
// the product register and the output register, and a stalled output freezes
// the whole compute pipeline. Results are Q16.16 dot products summed exactly,
// floored and saturated, with tlast on the final one.
// A register value of zero acts as one and a value above MAX_DIM as MAX_DIM.
// Extra A elements beyond rows_a * inner_dim are dropped until the beat that completes B.
module matrix_multiply_top import mm_pkg::*; #(
  parameter int MAX_DIM    = DEFAULT_MAX_DIM,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,  // [31:0] element
  input  logic [0:0]         s_axis_tuser,  // [0] action
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,  // [31:0] product
  output logic               m_axis_tlast
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0]  rows_q, inner_q, cols_q;
  logic [DIM_W-1:0]  nr, nk, nc;
  logic              cfg_write;

  logic              in_beat;
  logic              advance;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
  mm_tag_t           issue;

  logic                         res_valid, res_last;
  logic signed [ELEM_WIDTH-1:0] res_data;

  logic              out_valid_q, out_valid_d;
  logic              out_last_q;
  logic [DATA_W-1:0] out_data_q;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_RESET;
      inner_q <= CFG_RESET;
      cols_q  <= CFG_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ROWS_A:    rows_q  <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_q <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:    prdata = DATA_W'(rows_q);
      REG_INNER_DIM: prdata = DATA_W'(inner_q);
      REG_COLS_B:    prdata = DATA_W'(cols_q);
      default:       prdata = '0;
    endcase
  end

  // Effective dimensions: zero acts as one, large values clamp to MAX_DIM.
  always_comb begin
    nr = (rows_q == '0) ? DIM_W'(1) :
         (rows_q > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_q);
    nk = (inner_q == '0) ? DIM_W'(1) :
         (inner_q > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_q);
    nc = (cols_q == '0) ? DIM_W'(1) :
         (cols_q > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_q);
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // The compute pipeline moves whenever the output register can take a beat.
  assign advance = !out_valid_q || m_axis_tready;

  mm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nr_i        (nr),
    .nk_i        (nk),
    .nc_i        (nc),
    .in_beat_i   (in_beat),
    .in_action_i (s_axis_tuser[0]),
    .advance_i   (advance),
    .in_ready_o  (s_axis_tready),
    .a_we_o      (a_we),
    .a_waddr_o   (a_waddr),
    .b_we_o      (b_we),
    .b_waddr_o   (b_waddr),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .issue_o     (issue)
  );

  mm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (s_axis_tdata[ELEM_WIDTH-1:0]),
    .re_i    (issue.valid && advance),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (s_axis_tdata[ELEM_WIDTH-1:0]),
    .re_i    (issue.valid && advance),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mm_mac #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .issue_i     (issue),
    .a_data_i    (a_rdata),
    .b_data_i    (b_rdata),
    .res_valid_o (res_valid),
    .res_last_o  (res_last),
    .res_data_o  (res_data)
  );

  // Output register.
  assign out_valid_d = advance ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= DATA_W'(res_data);
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // Loading and computing never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !issue.valid)
    else $error("input taken while the product is being computed");

  // A frozen pipeline keeps its read addresses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue.valid && !advance) |=> ($stable(a_raddr) && $stable(b_raddr)))
    else $error("read addresses moved during a stall");

  // The final result of a matrix closes a dot product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_last && !res_valid) |-> 1'b0)
    else $error("last flag outside a finished dot product");
`endif

endmodule

[design/mm_ram.sv]
module mm_ram import mm_pkg::*; #(
  parameter int DEPTH = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM,
  parameter int WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mm_seq.sv]
module mm_seq import mm_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(MAX_DIM+1)-1:0]         nr_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]         nk_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]         nc_i,
  input  logic                                 in_beat_i,
  input  logic                                 in_action_i,
  input  logic                                 advance_i,
  output logic                                 in_ready_o,
  output logic                                 a_we_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_waddr_o,
  output logic                                 b_we_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_waddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_raddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_raddr_o,
  output mm_tag_t                              issue_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);

  mm_state_e state_q, state_d;

  logic [CNT_W-1:0]   a_cnt_q, a_cnt_d;
  logic [CNT_W-1:0]   b_cnt_q, b_cnt_d;
  logic [IDX_W-1:0]   k_q, k_d, j_q, j_d, i_q, i_d;
  logic [ADDR_W-1:0]  ia_q, ia_d, ra_q, ra_d, ib_q, ib_d;

  logic [2*DIM_W-1:0] a_prod, b_prod;
  logic [CNT_W-1:0]   a_size, b_size;
  logic [CNT_W-1:0]   b_idx, b_next;
  logic               b_done;
  logic               last_k, last_j, last_i;
  logic               issue_valid;

  // Matrix sizes in elements.
  assign a_prod = nr_i * nk_i;
  assign b_prod = nk_i * nc_i;
  assign a_size = CNT_W'(a_prod);
  assign b_size = CNT_W'(b_prod);

  // B loading restarts at index zero when the count already reached or passed the size.
  assign b_idx  = (b_cnt_q >= b_size) ? '0 : b_cnt_q;
  assign b_next = b_idx + 1'b1;
  assign b_done = in_beat_i && in_action_i && (b_next == b_size);

  assign last_k = (k_q == IDX_W'(nk_i - 1'b1));
  assign last_j = (j_q == IDX_W'(nc_i - 1'b1));
  assign last_i = (i_q == IDX_W'(nr_i - 1'b1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (b_done) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance_i && last_k && last_j && last_i) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    issue_valid = 1'b0;
    case (state_q)
      ST_LOAD: in_ready_o  = 1'b1;
      ST_RUN:  issue_valid = 1'b1;
      default: in_ready_o  = 1'b0;
    endcase
  end

  // Store writes and the element counts.
  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    a_we_o  = 1'b0;
    b_we_o  = 1'b0;
    if (in_beat_i && !in_action_i && (a_cnt_q < a_size)) begin
      a_we_o  = 1'b1;
      a_cnt_d = a_cnt_q + 1'b1;
    end
    if (in_beat_i && in_action_i) begin
      b_we_o  = 1'b1;
      b_cnt_d = b_done ? '0 : b_next;
      if (b_done) begin
        a_cnt_d = '0;
      end
    end
  end

  assign a_waddr_o = a_cnt_q[ADDR_W-1:0];
  assign b_waddr_o = b_idx[ADDR_W-1:0];

  // Walk i, j and k; A and B addresses follow by adds only.
  always_comb begin
    k_d  = k_q;
    j_d  = j_q;
    i_d  = i_q;
    ia_d = ia_q;
    ra_d = ra_q;
    ib_d = ib_q;
    if (b_done) begin
      k_d  = '0;
      j_d  = '0;
      i_d  = '0;
      ia_d = '0;
      ra_d = '0;
      ib_d = '0;
    end else if (issue_valid && advance_i) begin
      if (!last_k) begin
        k_d  = k_q + 1'b1;
        ia_d = ia_q + 1'b1;
        ib_d = ib_q + ADDR_W'(nc_i);
      end else if (!last_j) begin
        k_d  = '0;
        j_d  = j_q + 1'b1;
        ia_d = ra_q;
        ib_d = ADDR_W'(j_q) + 1'b1;
      end else begin
        k_d  = '0;
        j_d  = '0;
        i_d  = i_q + 1'b1;
        ra_d = ra_q + ADDR_W'(nk_i);
        ia_d = ra_q + ADDR_W'(nk_i);
        ib_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      k_q     <= '0;
      j_q     <= '0;
      i_q     <= '0;
      ia_q    <= '0;
      ra_q    <= '0;
      ib_q    <= '0;
    end else begin
      state_q <= state_d;
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      k_q     <= k_d;
      j_q     <= j_d;
      i_q     <= i_d;
      ia_q    <= ia_d;
      ra_q    <= ra_d;
      ib_q    <= ib_d;
    end
  end

  assign a_raddr_o        = ia_q;
  assign b_raddr_o        = ib_q;
  assign issue_o.valid    = issue_valid;
  assign issue_o.last_k   = last_k;
  assign issue_o.last_all = issue_valid && last_k && last_j && last_i;

endmodule

[design/mm_mac.sv]
module mm_mac import mm_pkg::*; #(
  parameter int MAX_DIM    = DEFAULT_MAX_DIM,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  mm_tag_t                      issue_i,
  input  logic [ELEM_WIDTH-1:0]        a_data_i,
  input  logic [ELEM_WIDTH-1:0]        b_data_i,
  output logic                         res_valid_o,
  output logic                         res_last_o,
  output logic signed [ELEM_WIDTH-1:0] res_data_o
);

  localparam int EW    = ELEM_WIDTH;
  localparam int ACC_W = 2 * EW + $clog2(MAX_DIM) + 1;

  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-EW+1){1'b1}}, {(EW-1){1'b0}}};

  mm_tag_t                  tag1_q, tag2_q;
  logic signed [2*EW-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  sum, shifted;

  // Exact product of the two store reads.
  assign prod_d = signed'(a_data_i) * signed'(b_data_i);

  // Full-width running sum; floor to the fraction format by arithmetic shift.
  assign sum     = acc_q + ACC_W'(prod_q);
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    acc_d = acc_q;
    if (tag2_q.valid) begin
      acc_d = tag2_q.last_k ? '0 : sum;
    end
  end

  // Saturate to the element range.
  always_comb begin
    if (shifted > SAT_MAX) begin
      res_data_o = SAT_MAX[EW-1:0];
    end else if (shifted < SAT_MIN) begin
      res_data_o = SAT_MIN[EW-1:0];
    end else begin
      res_data_o = shifted[EW-1:0];
    end
  end

  assign res_valid_o = tag2_q.valid && tag2_q.last_k;
  assign res_last_o  = tag2_q.last_all;

  // Control tags and the accumulator; the whole pipe holds while frozen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      acc_q  <= '0;
    end else if (advance_i) begin
      tag1_q <= issue_i;
      tag2_q <= tag1_q;
      acc_q  <= acc_d;
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
    end
  end

endmodule

[dv/tb_matrix_multiply_top.sv]
module tb_matrix_multiply_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  // Stream selector values carried on s_axis_tuser.
  localparam logic ACT_LOAD_A = 1'b0;
  localparam logic ACT_LOAD_B = 1'b1;

  localparam int STORE_DEPTH  = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM;
  localparam int ITEMS        = 420;
  localparam int QUIET_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 500000;
  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic              is_last;
  } c_elem_t;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] elem;
  } beat_t;

  // Predicts every element of C from the A and B beats and checks the output.
  class product_scoreboard;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] cols_reg;
    int               a_mem[STORE_DEPTH];
    int               b_mem[STORE_DEPTH];
    int unsigned      a_cnt;
    int unsigned      b_cnt;
    int unsigned      a_top;
    c_elem_t          c_expected[$];
    int               errors;

    function new();
      rows_reg  = CFG_RESET;
      inner_reg = CFG_RESET;
      cols_reg  = CFG_RESET;
      a_cnt     = 0;
      b_cnt     = 0;
      a_top     = 0;
      errors    = 0;
    endfunction

    // Zero acts as one and anything above the maximum acts as the maximum.
    function int unsigned eff(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
      return v;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_ROWS_A:    rows_reg  = value;
        REG_INNER_DIM: inner_reg = value;
        REG_COLS_B:    cols_reg  = value;
        default: ;
      endcase
    endfunction

    function void check_reg(logic [1:0] idx, logic [DATA_W-1:0] rd);
      logic [CFG_W-1:0] value;
      case (idx)
        REG_ROWS_A:    value = rows_reg;
        REG_INNER_DIM: value = inner_reg;
        default:       value = cols_reg;
      endcase
      if (rd !== DATA_W'(value))
        note_failure($sformatf("register %0d read %h, expected %h", idx, rd, value));
    endfunction

    // Exact sum of Q32.32 products, floored to Q16.16 and saturated.
    function logic [DATA_W-1:0] dot(int unsigned row, int unsigned col,
                                    int unsigned nk, int unsigned nc);
      logic signed [71:0] acc;
      logic signed [71:0] floored;
      longint             term;
      acc = '0;
      for (int unsigned k = 0; k < nk; k++) begin
        term = longint'(a_mem[row * nk + k]) * longint'(b_mem[k * nc + col]);
        acc  = acc + term;
      end
      floored = acc >>> FRAC_BITS;
      if (floored > Q_MAX) return 32'h7FFF_FFFF;
      if (floored < Q_MIN) return 32'h8000_0000;
      return floored[DATA_W-1:0];
    endfunction

    function void note_element(logic action, logic [DATA_W-1:0] elem);
      int unsigned nr;
      int unsigned nk;
      int unsigned nc;
      nr = eff(rows_reg);
      nk = eff(inner_reg);
      nc = eff(cols_reg);
      if (action == ACT_LOAD_A) begin
        // A beats past the end of the matrix are dropped.
        if (a_cnt < nr * nk) begin
          a_mem[a_cnt] = int'(elem);
          a_cnt++;
          if (a_cnt > a_top) a_top = a_cnt;
        end
      end else begin
        if (b_cnt >= nk * nc) b_cnt = 0;
        b_mem[b_cnt] = int'(elem);
        b_cnt++;
        // The beat that completes B releases the whole of C.
        if (b_cnt == nk * nc) begin
          for (int unsigned i = 0; i < nr; i++) begin
            for (int unsigned j = 0; j < nc; j++) begin
              c_expected.push_back('{product: dot(i, j, nk, nc),
                                     is_last: (i == nr - 1) && (j == nc - 1)});
            end
          end
          a_cnt = 0;
          b_cnt = 0;
        end
      end
    endfunction

    function void check_product(logic [DATA_W-1:0] data, logic last);
      c_elem_t want;
      if (c_expected.size() == 0) begin
        note_failure($sformatf("unexpected product %h last %b", data, last));
        return;
      end
      want = c_expected.pop_front();
      if (data !== want.product || last !== want.is_last)
        note_failure($sformatf("product %h last %b, expected %h last %b",
                               data, last, want.product, want.is_last));
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0]  pwdata        = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] element
  logic [0:0]         s_axis_tuser  = '0;  // [0] action
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;      // [31:0] product
  logic               m_axis_tlast;

  product_scoreboard sb = new();

  beat_t       beat_q[$];
  int unsigned gen_a_cnt;
  int unsigned gen_b_cnt;
  int unsigned gen_a_top;
  logic        gen_frame_done;
  int          beats_sent = 0;
  logic        idle_en = 1'b1;
  int          stall_left = 0;
  int          cycle_count = 0;

  matrix_multiply_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix_multiply_top verification failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_product(m_axis_tdata, m_axis_tlast);
    if (stall_left > 0) stall_left--;
    else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
    m_axis_tready <= (stall_left == 0);
  end

  // Mix of extremes, full-range words and small Q16.16 values.
  function automatic logic [DATA_W-1:0] rand_elem();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          4:       v = 32'h0000_0001;
          5:       v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      1, 2:    v = $urandom();
      default: v = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    logic [CFG_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = 0;
      1:       v = CFG_W'($urandom_range(9, 15));
      2, 3:    v = CFG_W'($urandom_range(4, 8));
      default: v = CFG_W'($urandom_range(1, 3));
    endcase
    return v;
  endfunction

  // Picks up the load counters once every queued beat has been taken.
  function automatic void start_frame();
    gen_a_cnt      = sb.a_cnt;
    gen_b_cnt      = sb.b_cnt;
    gen_a_top      = sb.a_top;
    gen_frame_done = 1'b0;
  endfunction

  // Queues one beat. Before a beat that completes B, A beats are added if
  // needed so that no A entry the product reads is left unwritten.
  function automatic void queue_beat(logic action, logic [DATA_W-1:0] elem);
    int unsigned a_size;
    int unsigned b_size;
    a_size = sb.eff(sb.rows_reg) * sb.eff(sb.inner_reg);
    b_size = sb.eff(sb.inner_reg) * sb.eff(sb.cols_reg);
    if (action == ACT_LOAD_A) begin
      if (gen_a_cnt < a_size) begin
        gen_a_cnt++;
        if (gen_a_cnt > gen_a_top) gen_a_top = gen_a_cnt;
      end
    end else begin
      if (gen_b_cnt >= b_size) gen_b_cnt = 0;
      if (gen_b_cnt + 1 == b_size)
        while (gen_a_top < a_size) queue_beat(ACT_LOAD_A, rand_elem());
      gen_b_cnt++;
      if (gen_b_cnt == b_size) begin
        gen_a_cnt      = 0;
        gen_b_cnt      = 0;
        gen_frame_done = 1'b1;
      end
    end
    beat_q.push_back('{action: action, elem: elem});
  endfunction

  // Random frame: mostly a well-formed A-then-B load, else interleaved or cut short.
  function automatic void queue_random_frame();
    int unsigned a_size;
    int unsigned b_size;
    int unsigned n_a;
    int unsigned n_b;
    int          kind;
    start_frame();
    a_size = sb.eff(sb.rows_reg) * sb.eff(sb.inner_reg);
    b_size = sb.eff(sb.inner_reg) * sb.eff(sb.cols_reg);
    kind   = $urandom_range(0, 9);
    if (kind < 7) begin
      n_a = (gen_a_cnt < a_size) ? a_size - gen_a_cnt : 0;
      case ($urandom_range(0, 7))
        0: n_a += $urandom_range(1, 3);
        1: if (gen_a_top >= a_size) n_a = $urandom_range(0, n_a);
        default: ;
      endcase
      n_b = (gen_b_cnt >= b_size) ? b_size : b_size - gen_b_cnt;
      repeat (n_a) queue_beat(ACT_LOAD_A, rand_elem());
      repeat (n_b) queue_beat(ACT_LOAD_B, rand_elem());
    end else if (kind == 7) begin
      while (!gen_frame_done) queue_beat(logic'($urandom_range(0, 1)), rand_elem());
    end else begin
      repeat ($urandom_range(1, 5)) queue_beat(logic'($urandom_range(0, 1)), rand_elem());
    end
  endfunction

  // Sends the queued beats, with random gaps while idling is enabled.
  task automatic send_beats();
    beat_t b;
    while (beat_q.size() != 0) begin
      b = beat_q.pop_front();
      if (idle_en && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b.elem;
      s_axis_tuser  <= b.action;
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_element(b.action, b.elem);
      beats_sent++;
      if (beats_sent >= ITEMS - QUIET_ITEMS) idle_en = 1'b0;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.check_reg(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write with random upper bits, then read the register back.
  task automatic apb_write(logic [1:0] idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    apb_read(idx);
  endtask

  // Waits for every expected product, then lets the pipeline run dry.
  task automatic settle();
    while (sb.c_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k,
                              logic [CFG_W-1:0] c);
    settle();
    apb_write(REG_ROWS_A, r);
    apb_write(REG_INNER_DIM, k);
    apb_write(REG_COLS_B, c);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the shape registers.
    apb_read(REG_ROWS_A);
    apb_read(REG_INNER_DIM);
    apb_read(REG_COLS_B);

    // Scalar products: saturation both ways and flooring of a tiny negative.
    program_dims(1, 1, 1);
    start_frame();
    queue_beat(ACT_LOAD_A, 32'h7FFF_FFFF);
    queue_beat(ACT_LOAD_B, 32'h7FFF_FFFF);
    queue_beat(ACT_LOAD_A, 32'h8000_0000);
    queue_beat(ACT_LOAD_B, 32'h7FFF_FFFF);
    queue_beat(ACT_LOAD_A, 32'hFFFF_FFFF);
    queue_beat(ACT_LOAD_B, 32'h0000_0001);
    queue_beat(ACT_LOAD_A, 32'h8000_0000);
    queue_beat(ACT_LOAD_B, 32'h8000_0000);
    // An extra A beat is dropped.
    queue_beat(ACT_LOAD_A, 32'h0001_0000);
    queue_beat(ACT_LOAD_A, 32'h7FFF_FFFF);
    queue_beat(ACT_LOAD_B, 32'h0002_0000);
    // B alone reuses the A left from the previous product.
    queue_beat(ACT_LOAD_B, 32'h0003_0000);
    send_beats();

    // Zero in every register acts as one.
    program_dims(0, 0, 0);
    start_frame();
    queue_beat(ACT_LOAD_A, 32'hFFFF_0000);
    queue_beat(ACT_LOAD_B, 32'h0000_8000);
    send_beats();

    // Shrinking the shape mid-load restarts the B count.
    program_dims(1, 2, 2);
    start_frame();
    queue_beat(ACT_LOAD_A, 32'h0001_0000);
    queue_beat(ACT_LOAD_A, 32'h0002_0000);
    repeat (3) queue_beat(ACT_LOAD_B, rand_elem());
    send_beats();
    program_dims(1, 1, 2);
    start_frame();
    queue_beat(ACT_LOAD_B, 32'h0001_8000);
    queue_beat(ACT_LOAD_B, 32'hFFFE_0000);
    send_beats();

    // Largest shape, once, with one value above the maximum.
    program_dims(8, 15, 8);
    start_frame();
    repeat (64) queue_beat(ACT_LOAD_A, rand_elem());
    repeat (64) queue_beat(ACT_LOAD_B, rand_elem());
    send_beats();

    // Random frames under changing shapes.
    while (beats_sent < ITEMS) begin
      if ($urandom_range(0, 2) == 0) program_dims(rand_dim(), rand_dim(), rand_dim());
      queue_random_frame();
      send_beats();
    end

    settle();
    if (sb.errors == 0 && sb.c_expected.size() == 0) begin
      $display("matrix_multiply_top verification clean");
    end else begin
      $display("matrix_multiply_top verification failed");
    end
    $finish;
  end

endmodule
